// ===== sv/psc_pkg.sv =====
`timescale 1ns / 1ps
package psc_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int PORT_BITS       = 16;
    localparam int THRESH_BITS     = 16;
    localparam int SUM_BITS        = 40;
    localparam int TOTAL_BITS      = SAMPLE_BITS + 2;
    localparam int ITEM_FIFO_DEPTH = 2;
    localparam int ITEM_PTR_BITS   = $clog2(ITEM_FIFO_DEPTH);
    localparam int ITEM_CNT_BITS   = ITEM_PTR_BITS + 1;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(249);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [TOTAL_BITS-1:0]  t_total;
    typedef logic [SUM_BITS-1:0]    t_sum;
    typedef logic [PORT_BITS-1:0]   t_port;

    // classified pixel, front to back
    typedef struct packed {
        t_sample blue;
        t_sample green;
        t_sample red;
        t_sample top;
        t_total  total;
        logic    unsat;
        logic    last;
    } t_item;

    typedef struct packed {
        logic  unsaturated;
        logic  stats_valid;
        t_sum  sum_blue;
        t_sum  sum_green;
        t_sum  sum_red;
        t_port bright_blue;
        t_port bright_green;
        t_port bright_red;
        t_port peak_value;
    } t_result;

endpackage

// ===== sv/psc_front.sv =====
`timescale 1ns / 1ps
module psc_front
    import psc_pkg::*;
(
    input  logic [PORT_BITS-1:0]   i_blue,
    input  logic [PORT_BITS-1:0]   i_green,
    input  logic [PORT_BITS-1:0]   i_red,
    input  logic                   i_frame_end,
    input  logic [THRESH_BITS-1:0] i_threshold,
    output t_item                  o_item
);

    t_sample b, g, r, top_bg, top;

    always_comb begin
        // bits above the sample width are dropped
        b      = i_blue[SAMPLE_BITS-1:0];
        g      = i_green[SAMPLE_BITS-1:0];
        r      = i_red[SAMPLE_BITS-1:0];
        top_bg = (g > b) ? g : b;
        top    = (r > top_bg) ? r : top_bg;

        o_item.blue  = b;
        o_item.green = g;
        o_item.red   = r;
        o_item.top   = top;
        o_item.total = TOTAL_BITS'(b) + TOTAL_BITS'(g) + TOTAL_BITS'(r);
        o_item.unsat = THRESH_BITS'(top) < i_threshold;
        o_item.last  = i_frame_end;
    end

endmodule

// ===== sv/psc_item_fifo.sv =====
`timescale 1ns / 1ps
module psc_item_fifo
    import psc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_wr_item,
    output logic  o_full,
    input  logic  i_rd,
    output t_item o_rd_item,
    output logic  o_empty
);

    t_item                    r_mem [ITEM_FIFO_DEPTH];
    logic [ITEM_PTR_BITS-1:0] r_wptr, r_rptr;
    logic [ITEM_CNT_BITS-1:0] r_count;
    logic                     wr_en, rd_en;

    assign o_full    = (r_count == ITEM_CNT_BITS'(ITEM_FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_item = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_item;
        end
    end

endmodule

// ===== sv/psc_back.sv =====
`timescale 1ns / 1ps
module psc_back
    import psc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_avail,
    input  t_item   i_item,
    output logic    o_item_take,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    t_sum    r_acc_blue, r_acc_green, r_acc_red;
    t_sum    n_acc_blue, n_acc_green, n_acc_red;
    t_total  r_best_sum, n_best_sum;
    t_sample r_best_blue, r_best_green, r_best_red;
    t_sample n_best_blue, n_best_green, n_best_red;
    t_sample r_peak, n_peak;
    logic    r_out_valid;
    t_result r_out, n_out;
    logic    out_free;

    // output register frees up in the same cycle its word is popped
    assign out_free    = !r_out_valid || i_pop;
    assign o_item_take = i_item_avail && out_free;
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_acc_blue   = r_acc_blue;
        n_acc_green  = r_acc_green;
        n_acc_red    = r_acc_red;
        n_best_sum   = r_best_sum;
        n_best_blue  = r_best_blue;
        n_best_green = r_best_green;
        n_best_red   = r_best_red;
        n_peak       = (i_item.top > r_peak) ? i_item.top : r_peak;
        if (i_item.unsat) begin
            n_acc_blue  = r_acc_blue + SUM_BITS'(i_item.blue);
            n_acc_green = r_acc_green + SUM_BITS'(i_item.green);
            n_acc_red   = r_acc_red + SUM_BITS'(i_item.red);
            // ties keep the earlier pixel
            if (i_item.total > r_best_sum) begin
                n_best_sum   = i_item.total;
                n_best_blue  = i_item.blue;
                n_best_green = i_item.green;
                n_best_red   = i_item.red;
            end
        end

        n_out             = '0;
        n_out.unsaturated = i_item.unsat;
        if (i_item.last) begin
            n_out.stats_valid  = 1'b1;
            n_out.sum_blue     = n_acc_blue;
            n_out.sum_green    = n_acc_green;
            n_out.sum_red      = n_acc_red;
            n_out.bright_blue  = PORT_BITS'(n_best_blue);
            n_out.bright_green = PORT_BITS'(n_best_green);
            n_out.bright_red   = PORT_BITS'(n_best_red);
            n_out.peak_value   = PORT_BITS'(n_peak);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_blue   <= '0;
            r_acc_green  <= '0;
            r_acc_red    <= '0;
            r_best_sum   <= '0;
            r_best_blue  <= '0;
            r_best_green <= '0;
            r_best_red   <= '0;
            r_peak       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_item_take) begin
                if (i_item.last) begin
                    // frame done, start the next one clean
                    r_acc_blue   <= '0;
                    r_acc_green  <= '0;
                    r_acc_red    <= '0;
                    r_best_sum   <= '0;
                    r_best_blue  <= '0;
                    r_best_green <= '0;
                    r_best_red   <= '0;
                    r_peak       <= '0;
                end else begin
                    r_acc_blue   <= n_acc_blue;
                    r_acc_green  <= n_acc_green;
                    r_acc_red    <= n_acc_red;
                    r_best_sum   <= n_best_sum;
                    r_best_blue  <= n_best_blue;
                    r_best_green <= n_best_green;
                    r_best_red   <= n_best_red;
                    r_peak       <= n_peak;
                end
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== sv/pixel_saturation_and_color_stats.sv =====
`timescale 1ns / 1ps
// One BGR pixel per clock in unless full, one word per pixel out, in order. A
// pushed pixel passes the item queue, then the output register, before it shows
// up on the result ports; with pop held high the block sustains one pixel per
// cycle, set by the single accumulate step of the back end. A two-word queue after
// the classifier absorbs short result stalls; with pixels streaming every cycle it
// already holds one word, so full can rise when the output word is not popped. The
// word of the frame_end pixel carries the frame sums, brightest unsaturated pixel
// and peak channel, and the frame state clears behind it. The threshold register
// is always ready and must be written only while no pixel is in flight.
module pixel_saturation_and_color_stats
    import psc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [THRESH_BITS-1:0] i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [PORT_BITS-1:0]   i_blue,
    input  logic [PORT_BITS-1:0]   i_green,
    input  logic [PORT_BITS-1:0]   i_red,
    input  logic                   i_frame_end,
    output logic                   empty,
    input  logic                   pop,
    output logic                   o_unsaturated,
    output logic                   o_stats_valid,
    output logic [SUM_BITS-1:0]    o_sum_blue,
    output logic [SUM_BITS-1:0]    o_sum_green,
    output logic [SUM_BITS-1:0]    o_sum_red,
    output logic [PORT_BITS-1:0]   o_bright_blue,
    output logic [PORT_BITS-1:0]   o_bright_green,
    output logic [PORT_BITS-1:0]   o_bright_red,
    output logic [PORT_BITS-1:0]   o_peak_value
);

    logic [THRESH_BITS-1:0] r_threshold;
    t_item                  front_item, q_item;
    logic                   q_empty, q_take;
    t_result                result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    psc_front u_front (
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_frame_end (i_frame_end),
        .i_threshold (r_threshold),
        .o_item      (front_item)
    );

    psc_item_fifo u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_item (front_item),
        .o_full    (full),
        .i_rd      (q_take),
        .o_rd_item (q_item),
        .o_empty   (q_empty)
    );

    psc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_avail (!q_empty),
        .i_item       (q_item),
        .o_item_take  (q_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (result)
    );

    assign o_unsaturated  = result.unsaturated;
    assign o_stats_valid  = result.stats_valid;
    assign o_sum_blue     = result.sum_blue;
    assign o_sum_green    = result.sum_green;
    assign o_sum_red      = result.sum_red;
    assign o_bright_blue  = result.bright_blue;
    assign o_bright_green = result.bright_green;
    assign o_bright_red   = result.bright_red;
    assign o_peak_value   = result.peak_value;

endmodule

// ===== tb/tb_pixel_saturation_and_color_stats.sv =====
`timescale 1ns / 1ps
module tb_pixel_saturation_and_color_stats;
    import psc_pkg::*;

    typedef struct packed {
        t_port blue;
        t_port green;
        t_port red;
        logic  frame_end;
    } t_rgb_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [THRESH_BITS-1:0] i_cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic [PORT_BITS-1:0]   i_blue = '0;
    logic [PORT_BITS-1:0]   i_green = '0;
    logic [PORT_BITS-1:0]   i_red = '0;
    logic                   i_frame_end = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   o_unsaturated;
    logic                   o_stats_valid;
    logic [SUM_BITS-1:0]    o_sum_blue;
    logic [SUM_BITS-1:0]    o_sum_green;
    logic [SUM_BITS-1:0]    o_sum_red;
    logic [PORT_BITS-1:0]   o_bright_blue;
    logic [PORT_BITS-1:0]   o_bright_green;
    logic [PORT_BITS-1:0]   o_bright_red;
    logic [PORT_BITS-1:0]   o_peak_value;

    pixel_saturation_and_color_stats dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_blue         (i_blue),
        .i_green        (i_green),
        .i_red          (i_red),
        .i_frame_end    (i_frame_end),
        .empty          (empty),
        .pop            (pop),
        .o_unsaturated  (o_unsaturated),
        .o_stats_valid  (o_stats_valid),
        .o_sum_blue     (o_sum_blue),
        .o_sum_green    (o_sum_green),
        .o_sum_red      (o_sum_red),
        .o_bright_blue  (o_bright_blue),
        .o_bright_green (o_bright_green),
        .o_bright_red   (o_bright_red),
        .o_peak_value   (o_peak_value)
    );

    t_rgb_word   pixels_to_send[$];
    t_result     stat_words_due[$];
    logic        pix_taken = 1'b0;
    logic        rx_hold = 1'b0;
    int unsigned sender_idle_pct = 7;
    int unsigned recv_idle_pct = 68;
    int          pixel_count = 0;
    int          errors = 0;

    // frame statistics shadow
    logic [THRESH_BITS-1:0] thresh_seen = THRESH_RESET;
    t_sum    run_blue = '0;
    t_sum    run_green = '0;
    t_sum    run_red = '0;
    t_total  best_total = '0;
    t_sample best_blue = '0;
    t_sample best_green = '0;
    t_sample best_red = '0;
    t_sample peak_seen = '0;

    function automatic t_result frame_stats_update(t_rgb_word px);
        t_sample b, g, r, top;
        t_total  total;
        t_result w;
        b = t_sample'(px.blue);
        g = t_sample'(px.green);
        r = t_sample'(px.red);
        top = b;
        if (g > top) top = g;
        if (r > top) top = r;
        if (top > peak_seen) peak_seen = top;
        total = t_total'(b) + t_total'(g) + t_total'(r);
        w = '0;
        w.unsaturated = (top < thresh_seen);
        if (w.unsaturated) begin
            run_blue  = run_blue + t_sum'(b);
            run_green = run_green + t_sum'(g);
            run_red   = run_red + t_sum'(r);
            // ties keep the earlier pixel
            if (total > best_total) begin
                best_total = total;
                best_blue  = b;
                best_green = g;
                best_red   = r;
            end
        end
        if (px.frame_end) begin
            w.stats_valid  = 1'b1;
            w.sum_blue     = run_blue;
            w.sum_green    = run_green;
            w.sum_red      = run_red;
            w.bright_blue  = t_port'(best_blue);
            w.bright_green = t_port'(best_green);
            w.bright_red   = t_port'(best_red);
            w.peak_value   = t_port'(peak_seen);
            run_blue   = '0;
            run_green  = '0;
            run_red    = '0;
            best_total = '0;
            best_blue  = '0;
            best_green = '0;
            best_red   = '0;
            peak_seen  = '0;
        end
        return w;
    endfunction

    function automatic t_port pick_sample(t_port th);
        case ($urandom_range(7))
            0, 1, 2: return t_port'($urandom_range(65535));
            3, 4:    return (th == '0) ? '0 : t_port'($urandom_range(th - 1));
            5:       return th + t_port'($urandom_range(2)) - t_port'(1);
            6:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < 50)
            $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic add_pixel(t_rgb_word px);
        pixels_to_send.insert(pixels_to_send.size(), px);
    endtask

    task automatic queue_pixel(t_port b, t_port g, t_port r, logic last);
        t_rgb_word px;
        px = '{b, g, r, last};
        add_pixel(px);
    endtask

    task automatic write_threshold(logic [THRESH_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_words();
        while (pixels_to_send.size() != 0 || stat_words_due.size() != 0)
            @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin : pixel_driver
        if (pix_taken)
            pixels_to_send.delete(0);
        if (pixels_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            push        <= 1'b1;
            i_blue      <= pixels_to_send[0].blue;
            i_green     <= pixels_to_send[0].green;
            i_red       <= pixels_to_send[0].red;
            i_frame_end <= pixels_to_send[0].frame_end;
        end else begin
            push <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : word_receiver
        pop <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : word_monitor
        t_result got, want;
        if (i_rst_n) begin
            // check the outgoing word before predicting the incoming pixel
            if (pop && !empty) begin
                got.unsaturated  = o_unsaturated;
                got.stats_valid  = o_stats_valid;
                got.sum_blue     = o_sum_blue;
                got.sum_green    = o_sum_green;
                got.sum_red      = o_sum_red;
                got.bright_blue  = o_bright_blue;
                got.bright_green = o_bright_green;
                got.bright_red   = o_bright_red;
                got.peak_value   = o_peak_value;
                if (stat_words_due.size() == 0) begin
                    report_mismatch("word with nothing due", 64'(got.unsaturated), 64'(0));
                end else begin
                    want = stat_words_due.pop_front();
                    if (got.unsaturated !== want.unsaturated)
                        report_mismatch("unsaturated", 64'(got.unsaturated),
                                        64'(want.unsaturated));
                    if (got.stats_valid !== want.stats_valid)
                        report_mismatch("stats_valid", 64'(got.stats_valid),
                                        64'(want.stats_valid));
                    if (got.sum_blue !== want.sum_blue)
                        report_mismatch("sum_blue", 64'(got.sum_blue), 64'(want.sum_blue));
                    if (got.sum_green !== want.sum_green)
                        report_mismatch("sum_green", 64'(got.sum_green), 64'(want.sum_green));
                    if (got.sum_red !== want.sum_red)
                        report_mismatch("sum_red", 64'(got.sum_red), 64'(want.sum_red));
                    if (got.bright_blue !== want.bright_blue)
                        report_mismatch("bright_blue", 64'(got.bright_blue),
                                        64'(want.bright_blue));
                    if (got.bright_green !== want.bright_green)
                        report_mismatch("bright_green", 64'(got.bright_green),
                                        64'(want.bright_green));
                    if (got.bright_red !== want.bright_red)
                        report_mismatch("bright_red", 64'(got.bright_red),
                                        64'(want.bright_red));
                    if (got.peak_value !== want.peak_value)
                        report_mismatch("peak_value", 64'(got.peak_value),
                                        64'(want.peak_value));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                thresh_seen = i_cfg_data;
            if (push && !full) begin
                stat_words_due.insert(stat_words_due.size(),
                    frame_stats_update('{i_blue, i_green, i_red, i_frame_end}));
                pixel_count++;
            end
        end
        pix_taken <= i_rst_n && push && !full;
    end

    // long output stalls while the sender keeps offering pixels
    initial begin
        wait (pixel_count >= 400);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (60) @(negedge i_clk);
        rx_hold <= 1'b0;
        wait (pixel_count >= 1000);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (80) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : stimulus
        int        n, flen;
        t_rgb_word px, px_prev;
        t_port     th;
        px_prev = '0;
        wait (i_rst_n);

        // reset threshold: zero pixel alone, boundary, ties, saturated peak
        queue_pixel(16'd0, 16'd0, 16'd0, 1'b1);
        queue_pixel(16'd248, 16'd0, 16'd0, 1'b0);
        queue_pixel(16'd0, 16'd248, 16'd0, 1'b0);
        queue_pixel(16'd0, 16'd0, 16'd249, 1'b0);
        queue_pixel(16'hffff, 16'hffff, 16'hffff, 1'b0);
        queue_pixel(16'd100, 16'd100, 16'd49, 1'b0);
        queue_pixel(16'd10, 16'd20, 16'd30, 1'b1);
        // frame with nothing unsaturated
        queue_pixel(16'd300, 16'd0, 16'd0, 1'b0);
        queue_pixel(16'd0, 16'd0, 16'hffff, 1'b1);
        drain_words();

        write_threshold('0);
        queue_pixel(16'd0, 16'd0, 16'd0, 1'b0);
        queue_pixel(16'd5, 16'd5, 16'd5, 1'b1);
        drain_words();

        write_threshold('1);
        queue_pixel(16'hfffe, 16'hfffe, 16'hfffe, 1'b0);
        queue_pixel(16'hffff, 16'd0, 16'd0, 1'b0);
        queue_pixel(16'hfffe, 16'd1, 16'd1, 1'b1);
        drain_words();

        write_threshold(16'd1);
        queue_pixel(16'd0, 16'd0, 16'd0, 1'b0);
        queue_pixel(16'd1, 16'd0, 16'd0, 1'b0);
        queue_pixel(16'd0, 16'd0, 16'd0, 1'b1);
        drain_words();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                sender_idle_pct = 68;
                recv_idle_pct   = 7;
            end else if (ph == 4) begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            case (ph)
                0:       th = t_port'($urandom_range(65535));
                1:       th = 16'd1000;
                2:       th = t_port'($urandom_range(255, 4095));
                3:       th = '1;
                4:       th = t_port'($urandom_range(1, 65534));
                default: th = 16'h8000;
            endcase
            write_threshold(th);
            n = 0;
            while (n < 205) begin
                flen = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
                for (int k = 0; k < flen; k++) begin
                    // a rotated copy of the previous pixel has the same channel sum
                    if ($urandom_range(7) == 0)
                        px = '{px_prev.green, px_prev.red, px_prev.blue, 1'b0};
                    else
                        px = '{pick_sample(th), pick_sample(th), pick_sample(th), 1'b0};
                    px.frame_end = (k == flen - 1);
                    add_pixel(px);
                    px_prev = px;
                    n++;
                end
            end
            drain_words();
        end

        repeat (8) @(posedge i_clk);
        if (stat_words_due.size() != 0)
            report_mismatch("words never delivered", 64'(stat_words_due.size()), 64'(0));
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        forever #10 i_clk = ~i_clk;
    end

endmodule
